@@ rtl/bld_pkg.sv @@
// types, constants and register codes shared by the block-linear deswizzle address blocks
// no dependencies
package bld_pkg;

  localparam int OFFSET_BITS = 33;
  localparam int MAX_BLOCK_GOBS_DEF = 16;

  localparam int COL_W = 14;
  localparam int ROW_W = 14;
  localparam int BPU_W = 5;
  localparam int LBH_W = 3;
  localparam int X_W = 19;
  localparam int WB_W = 20;
  localparam int GPR_W = 14;
  localparam int BY_W = 11;
  localparam int BG_W = 25;
  localparam int GT_W = 19;
  localparam int INTRA_W = 9;
  localparam int PD_W = 34;
  localparam int DST_W = 35;
  localparam int LIN_W = 35;
  localparam int SRC_W = 40;
  localparam int QDEPTH = 2;

  localparam logic [7:0] UNIT_CODE_RESET = 8'd4;
  localparam logic [7:0] BITS_THRESHOLD = 8'd16;

  typedef enum logic [1:0] {
    REG_WIDTH_UNITS    = 2'd0,
    REG_HEIGHT_ROWS    = 2'd1,
    REG_UNIT_SIZE_CODE = 2'd2,
    REG_SOURCE_BYTES   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [14:0] width_units;
    logic [14:0] height_rows;
    logic [7:0]  unit_size_code;
    logic [31:0] source_bytes;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] unit_column;
    logic [ROW_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] source_offset;
    logic [OFFSET_BITS-1:0] dest_offset;
    logic                   copy_ok;
    logic                   bad_setup;
  } result_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [X_W-1:0]   x;
    logic [WB_W-1:0]  wb;
    logic [BPU_W-1:0] bpu;
    logic [LBH_W-1:0] lbh;
    logic             bad;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } push_t;

endpackage

@@ rtl/block_linear_deswizzle_address_core.sv @@
// top level of the block-linear deswizzle address generator: config registers,
// front, queue and back; depends on bld_pkg, bld_front, bld_queue, bld_back
//
//   channel   handshake         payload     direction
//   input     start / busy      item        in
//   result    done (strobe)     result      out
//   config    cfg_wr            cfg_index,  in
//                               cfg_data
//
// one item per clock sustained
// latency is set by the front register, the queue slot and the three back stages
// reset clears the config registers to their defaults and empties the pipeline
// the back end drains every cycle, so busy rises only if the queue were to fill
module block_linear_deswizzle_address_core #(
  parameter int MAX_BLOCK_GOBS = bld_pkg::MAX_BLOCK_GOBS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bld_pkg::item_t   item,
  output logic             done,
  output bld_pkg::result_t result,
  input  logic             cfg_wr,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import bld_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  q_ready;
  logic  pop_valid;
  work_t pop_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_units <= '0;
      cfg.height_rows <= '0;
      cfg.unit_size_code <= UNIT_CODE_RESET;
      cfg.source_bytes <= '0;
    end else if (cfg_wr) begin
      case (reg_index_t'(cfg_index))
        REG_WIDTH_UNITS: begin
          cfg.width_units <= cfg_data[14:0];
        end
        REG_HEIGHT_ROWS: begin
          cfg.height_rows <= cfg_data[14:0];
        end
        REG_UNIT_SIZE_CODE: begin
          cfg.unit_size_code <= cfg_data[7:0];
        end
        REG_SOURCE_BYTES: begin
          cfg.source_bytes <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  bld_front #(
    .MAX_BLOCK_GOBS(MAX_BLOCK_GOBS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg(cfg),
    .q_ready(q_ready),
    .push(push)
  );

  bld_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .q_ready(q_ready),
    .pop_valid(pop_valid),
    .pop_work(pop_work)
  );

  bld_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pop_valid(pop_valid),
    .pop_work(pop_work),
    .done(done),
    .result(result)
  );

endmodule

@@ rtl/bld_front.sv @@
// front end: takes the input beat, works out unit size, byte column, row pitch,
// block height and setup check; depends on bld_pkg
module bld_front #(
  parameter int MAX_BLOCK_GOBS = bld_pkg::MAX_BLOCK_GOBS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bld_pkg::item_t item,
  input  bld_pkg::cfg_t  cfg,
  input  logic           q_ready,
  output bld_pkg::push_t push
);
  import bld_pkg::*;

  localparam int CAP_LOG = $clog2(MAX_BLOCK_GOBS);

  logic [BPU_W-1:0] bpu;
  logic [12:0]      gobs;
  logic [3:0]       lbh_raw;
  logic [LBH_W-1:0] lbh;
  logic [X_W-1:0]   x;
  logic [WB_W-1:0]  wb;
  logic             bad;
  logic             advance;
  logic             accept;
  logic             valid;
  work_t            work;

  always_comb begin
    if (cfg.unit_size_code > BITS_THRESHOLD) begin
      bpu = BPU_W'(cfg.unit_size_code >> 3);
    end else begin
      bpu = BPU_W'(cfg.unit_size_code);
    end
    gobs = 13'((16'(cfg.height_rows) + 16'd7) >> 3);
    lbh_raw = 4'd0;
    for (int i = 1; i < 13; i++) begin
      if (gobs[i]) begin
        lbh_raw = 4'(i);
      end
    end
    if (lbh_raw > 4'(CAP_LOG)) begin
      lbh = LBH_W'(CAP_LOG);
    end else begin
      lbh = LBH_W'(lbh_raw);
    end
    x = X_W'(item.unit_column) * X_W'(bpu);
    wb = WB_W'(cfg.width_units) * WB_W'(bpu);
    bad = (cfg.width_units == '0) || (cfg.height_rows == '0) ||
          (cfg.unit_size_code == '0) || (cfg.source_bytes == '0);
  end

  assign advance = !valid || q_ready;
  assign busy = !advance;
  assign accept = start && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work.row <= item.row;
      work.x <= x;
      work.wb <= wb;
      work.bpu <= bpu;
      work.lbh <= lbh;
      work.bad <= bad;
    end
  end

  assign push.valid = valid;
  assign push.work = work;

`ifndef NO_ASSERTIONS
  a_accept_pushes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> push.valid)
    else $error("accepted beat not presented to queue");
`endif

endmodule

@@ rtl/bld_queue.sv @@
// short queue between front and back; back drains one entry per cycle
// depends on bld_pkg
module bld_queue (
  input  logic           clk,
  input  logic           rst,
  input  bld_pkg::push_t push,
  output logic           q_ready,
  output logic           pop_valid,
  output bld_pkg::work_t pop_work
);
  import bld_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  work_t            mem [QDEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_push;

  assign pop_valid = count != '0;
  assign q_ready = (count != CNT_W'(QDEPTH)) || pop_valid;
  assign do_push = push.valid && q_ready;
  assign pop_work = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !pop_valid) begin
      count_next = count + CNT_W'(1);
    end else if (!do_push && pop_valid) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.work;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    do_push |=> pop_valid)
    else $error("pushed entry not visible to back end");
`endif

endmodule

@@ rtl/bld_back.sv @@
// back end: three-stage address pipeline for GOB offset, linear offset and bounds
// depends on bld_pkg
module bld_back (
  input  logic             clk,
  input  logic             rst,
  input  bld_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  input  bld_pkg::work_t   pop_work,
  output logic             done,
  output bld_pkg::result_t result
);
  import bld_pkg::*;

  logic [BY_W-1:0]    block_y;
  logic [BY_W-1:0]    gob_rows;
  logic [GPR_W-1:0]   gpr;
  logic [4:0]         gob_y;
  logic [12:0]        gob_x;
  logic [INTRA_W-1:0] intra;

  logic               v1;
  logic [BG_W-1:0]    bg1;
  logic [GT_W-1:0]    gt1;
  logic [INTRA_W-1:0] intra1;
  logic [LBH_W-1:0]   lbh1;
  logic [PD_W-1:0]    pdst1;
  logic [X_W-1:0]     x1;
  logic [LIN_W-1:0]   lin1;
  logic [BPU_W-1:0]   bpu1;
  logic               bad1;

  logic               v2;
  logic [SRC_W-1:0]   src2;
  logic [DST_W-1:0]   dst2;
  logic [LIN_W-1:0]   lin2;
  logic [BPU_W-1:0]   bpu2;
  logic               bad2;

  logic               src_fit;
  logic               dst_fit;

  always_comb begin
    gob_rows = BY_W'(pop_work.row >> 3);
    block_y = BY_W'(pop_work.row >> (3 + pop_work.lbh));
    gob_y = 5'(gob_rows & ~(BY_W'({BY_W{1'b1}}) << pop_work.lbh));
    gpr = GPR_W'((21'(pop_work.wb) + 21'd63) >> 6);
    gob_x = 13'(pop_work.x >> 6);
    intra = {pop_work.x[5], pop_work.row[2:1], pop_work.x[4], pop_work.row[0],
             pop_work.x[3:0]};
  end

  // stage 1: products and in-GOB bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    bg1 <= BG_W'(block_y) * BG_W'(gpr);
    gt1 <= (GT_W'(gob_x) << pop_work.lbh) + GT_W'(gob_y);
    intra1 <= intra;
    lbh1 <= pop_work.lbh;
    pdst1 <= PD_W'(pop_work.row) * PD_W'(pop_work.wb);
    x1 <= pop_work.x;
    lin1 <= LIN_W'(pop_work.wb) * LIN_W'(cfg.height_rows);
    bpu1 <= pop_work.bpu;
    bad1 <= pop_work.bad;
  end

  // stage 2: offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    src2 <= (((SRC_W'(bg1) << lbh1) + SRC_W'(gt1)) << 9) | SRC_W'(intra1);
    dst2 <= DST_W'(pdst1) + DST_W'(x1);
    lin2 <= lin1;
    bpu2 <= bpu1;
    bad2 <= bad1;
  end

  // stage 3: bounds and output register
  assign src_fit = (41'(src2) + 41'(bpu2)) <= 41'(cfg.source_bytes);
  assign dst_fit = (36'(dst2) + 36'(bpu2)) <= 36'(lin2);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    result.source_offset <= OFFSET_BITS'(src2);
    result.dest_offset <= OFFSET_BITS'(dst2);
    result.copy_ok <= !bad2 && src_fit && dst_fit;
    result.bad_setup <= bad2;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> ##3 done)
    else $error("popped entry did not produce a beat three cycles on");
  a_ok_vs_bad: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.copy_ok && result.bad_setup))
    else $error("copy_ok raised with bad setup");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (!pop_valid && !v1 && !v2) |=> !done)
    else $error("result beat with nothing in flight");
`endif

endmodule

@@ sim/block_linear_deswizzle_address_core_test.sv @@
// self-checking bench for block_linear_deswizzle_address_core: directed and random unit beats
// checked against an in-bench offset predictor; depends on bld_pkg and the core
module block_linear_deswizzle_address_core_test;
  import bld_pkg::*;

  localparam int BLOCK_GOB_CAP = MAX_BLOCK_GOBS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int END_SETTLE = 12;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_UNITS = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t unit_in = '0;
  logic done;
  result_t offsets_out;
  logic cfg_wr = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH_UNITS;
  logic [31:0] cfg_data = '0;

  cfg_t surface_cfg;
  result_t expected_offsets_q[$];
  int idle_pct = 36;
  int error_count = 0;
  int units_sent = 0;
  int offsets_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  block_linear_deswizzle_address_core #(
    .MAX_BLOCK_GOBS(BLOCK_GOB_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(unit_in),
    .done(done),
    .result(offsets_out),
    .cfg_wr(cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] unit_byte_count(logic [7:0] code);
    return (code > BITS_THRESHOLD) ? 64'(code / 8) : 64'(code);
  endfunction

  function automatic logic [63:0] gobs_per_block(logic [14:0] height);
    logic [63:0] gobs;
    logic [63:0] bh;
    gobs = (64'(height) + 7) / 8;
    bh = 1;
    while (bh < BLOCK_GOB_CAP && bh * 2 <= gobs) bh = bh * 2;
    return bh;
  endfunction

  function automatic result_t predict_offsets(item_t u);
    logic [63:0] bpu, wb, lin, bh, gpr, lines, x, y;
    logic [63:0] by, yib, gy, yg, gx, xg, intra, src, dst;
    logic bad, ok;
    result_t r;
    bpu = unit_byte_count(surface_cfg.unit_size_code);
    wb = 64'(surface_cfg.width_units) * bpu;
    lin = wb * 64'(surface_cfg.height_rows);
    bh = gobs_per_block(surface_cfg.height_rows);
    gpr = (wb + 63) / 64;
    lines = bh * 8;
    x = 64'(u.unit_column) * bpu;
    y = 64'(u.row);
    by = y / lines;
    yib = y % lines;
    gy = yib / 8;
    yg = yib % 8;
    gx = x / 64;
    xg = x % 64;
    // x bit 5 lands on offset bit 8
    intra = (xg & 64'h0F) | ((yg & 64'h01) << 4) | ((xg & 64'h10) << 1)
          | ((yg & 64'h06) << 5) | ((xg & 64'h20) << 3);
    src = by * gpr * bh * 512 + (gx * bh + gy) * 512 + intra;
    dst = y * wb + x;
    bad = (surface_cfg.width_units == 0) || (surface_cfg.height_rows == 0)
       || (surface_cfg.unit_size_code == 0) || (surface_cfg.source_bytes == 0);
    ok = !bad && (src + bpu <= 64'(surface_cfg.source_bytes)) && (dst + bpu <= lin);
    r.source_offset = src[OFFSET_BITS-1:0];
    r.dest_offset = dst[OFFSET_BITS-1:0];
    r.copy_ok = ok;
    r.bad_setup = bad;
    return r;
  endfunction

  function automatic logic [31:0] swizzled_bytes(cfg_t c);
    logic [63:0] bpu, gpr, bh, total;
    bpu = unit_byte_count(c.unit_size_code);
    gpr = (64'(c.width_units) * bpu + 63) / 64;
    bh = gobs_per_block(c.height_rows);
    total = ((64'(c.height_rows) + bh * 8 - 1) / (bh * 8)) * gpr * bh * 512;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  // result checker: a result is only on the port for one cycle
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_offsets_q.size() == 0) begin
        $error("unexpected result beat: source_offset %0h dest_offset %0h",
               offsets_out.source_offset, offsets_out.dest_offset);
        error_count++;
      end else begin
        want = expected_offsets_q.pop_front();
        offsets_checked++;
        if (offsets_out.source_offset !== want.source_offset) begin
          $error("source_offset expected %0h actual %0h",
                 want.source_offset, offsets_out.source_offset);
          error_count++;
        end
        if (offsets_out.dest_offset !== want.dest_offset) begin
          $error("dest_offset expected %0h actual %0h",
                 want.dest_offset, offsets_out.dest_offset);
          error_count++;
        end
        if (offsets_out.copy_ok !== want.copy_ok) begin
          $error("copy_ok expected %0b actual %0b", want.copy_ok, offsets_out.copy_ok);
          error_count++;
        end
        if (offsets_out.bad_setup !== want.bad_setup) begin
          $error("bad_setup expected %0b actual %0b", want.bad_setup, offsets_out.bad_setup);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_unit(logic [13:0] col, logic [13:0] row);
    item_t u;
    u.unit_column = col;
    u.row = row;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    unit_in <= u;
    do @(posedge clk); while (busy);
    expected_offsets_q.push_back(predict_offsets(u));
    units_sent++;
  endtask

  task automatic wait_results;
    start <= 1'b0;
    while (expected_offsets_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_surface(logic [14:0] w, logic [14:0] h, logic [7:0] code,
                             logic [31:0] src_size);
    cfg_t c;
    c.width_units = w;
    c.height_rows = h;
    c.unit_size_code = code;
    c.source_bytes = src_size;
    wait_results();
    for (int i = 0; i < 4; i++) begin
      cfg_wr <= 1'b1;
      case (i)
        0: begin cfg_index <= REG_WIDTH_UNITS;    cfg_data <= 32'(w);    end
        1: begin cfg_index <= REG_HEIGHT_ROWS;    cfg_data <= 32'(h);    end
        2: begin cfg_index <= REG_UNIT_SIZE_CODE; cfg_data <= 32'(code); end
        default: begin cfg_index <= REG_SOURCE_BYTES; cfg_data <= src_size; end
      endcase
      @(posedge clk);
    end
    cfg_wr <= 1'b0;
    surface_cfg = c;
    settings_used++;
  endtask

  task automatic set_fitted_surface(logic [14:0] w, logic [14:0] h, logic [7:0] code);
    cfg_t c;
    c.width_units = w;
    c.height_rows = h;
    c.unit_size_code = code;
    c.source_bytes = '0;
    set_surface(w, h, code, swizzled_bytes(c));
  endtask

  task automatic test_reset_setup;
    surface_cfg.width_units = '0;
    surface_cfg.height_rows = '0;
    surface_cfg.unit_size_code = UNIT_CODE_RESET;
    surface_cfg.source_bytes = '0;
    send_unit(14'd0, 14'd0);
    send_unit(14'h3FFF, 14'h3FFF);
  endtask

  task automatic test_gob_layout;
    int cols [6] = '{1, 16, 32, 63, 64, 127};
    int rows [5] = '{1, 6, 7, 8, 63};
    set_fitted_surface(15'd128, 15'd64, 8'd1);
    foreach (cols[i]) send_unit(14'(cols[i]), 14'd0);
    foreach (rows[i]) send_unit(14'd0, 14'(rows[i]));
    send_unit(14'd127, 14'd63);
  endtask

  task automatic test_unit_codes;
    set_fitted_surface(15'd40, 15'd20, 8'd17);
    send_unit(14'd39, 14'd19);
    set_fitted_surface(15'd40, 15'd20, 8'd128);
    send_unit(14'd33, 14'd17);
    set_fitted_surface(15'd40, 15'd20, 8'd16);
    send_unit(14'd33, 14'd17);
    set_surface(15'd40, 15'd20, 8'd0, 32'd4096);
    send_unit(14'd3, 14'd2);
  endtask

  task automatic test_extremes;
    set_surface(15'd16384, 15'd16384, 8'd128, 32'hFFFF_FFFF);
    send_unit(14'h3FFF, 14'h3FFF);
    send_unit(14'd0, 14'd0);
    // height zero falls back to one gob per block
    set_surface(15'd64, 15'd0, 8'd4, 32'd65536);
    send_unit(14'd5, 14'd9);
    set_surface(15'd64, 15'd32, 8'd4, 32'd0);
    send_unit(14'd5, 14'd9);
  endtask

  function automatic logic [14:0] random_extent;
    case ($urandom_range(9))
      0: return 15'd16384;
      1: return 15'($urandom_range(1, 16384));
      2, 3, 4: return 15'($urandom_range(1, 512));
      default: return 15'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic test_random_surfaces;
    logic [7:0] codes [10] = '{1, 2, 4, 8, 16, 17, 24, 64, 128, 3};
    logic [14:0] w, h;
    logic [7:0] code;
    logic [31:0] fit;
    cfg_t c;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      w = random_extent();
      h = random_extent();
      code = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 128))
                                      : codes[$urandom_range(9)];
      if (p == 3) w = 15'd0;
      c.width_units = w;
      c.height_rows = h;
      c.unit_size_code = code;
      c.source_bytes = '0;
      fit = swizzled_bytes(c);
      case ($urandom_range(5))
        0: fit = fit - 1;
        1: fit = $urandom();
        2: fit = 32'hFFFF_FFFF;
        default: ;
      endcase
      set_surface(w, h, code, fit);
      idle_pct = (p == 5) ? 0 : 36;
      for (int i = 0; i < PHASE_UNITS; i++) begin
        if ($urandom_range(3) != 0 && w != 0 && h != 0)
          send_unit(14'($urandom_range(0, (w > 16384 ? 16384 : w) - 1)),
                    14'($urandom_range(0, (h > 16384 ? 16384 : h) - 1)));
        else
          send_unit(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
      end
    end
    idle_pct = 36;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_setup();
    test_gob_layout();
    test_unit_codes();
    test_extremes();
    test_random_surfaces();
    wait_results();
    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d unit beats over %0d surface settings, %0d results checked",
             units_sent, settings_used, offsets_checked);
    $display("settings spanned invalid setups, bit-sized units and the largest surface");
    if (error_count == 0 && expected_offsets_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
